// File: hdl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants for the replay ring buffer.
// ----------------------------------------------------------------------------
package rrb_pkg;

   localparam int DATA_WIDTH    = 64;
   localparam int RANDOM_WIDTH  = 31;
   localparam int FILL_WIDTH    = 10;
   localparam int PURGE_DIVISOR = 5;

   typedef enum logic [0:0] {
      OP_ADD    = 1'b0,
      OP_SAMPLE = 1'b1
   } rrb_op_type;

   typedef struct packed {
      rrb_op_type              op;
      logic [DATA_WIDTH-1:0]   data;
      logic [RANDOM_WIDTH-1:0] rnd;
      logic                    last;
   } rrb_item_type;

   typedef struct packed {
      logic         valid;
      rrb_item_type item;
   } rrb_queue_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_RESP
   } rrb_state_type;

endpackage

// File: hdl/rrb_front.sv
// ----------------------------------------------------------------------------
// rrb_front
// Accepts request words, decodes the operation and queues them (2 deep).
// ----------------------------------------------------------------------------
module rrb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [rrb_pkg::DATA_WIDTH-1:0]   req_entry_data,
   input  logic [rrb_pkg::RANDOM_WIDTH-1:0] req_random_value,
   input  logic                         req_batch_last,
   output rrb_pkg::rrb_queue_type       queue_out,
   input  logic                         queue_pop
);
   import rrb_pkg::*;

   rrb_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         push;
   logic         pop;
   rrb_item_type item_dec;

   always_comb begin
      unique case (req_kind)
         1'b0:    item_dec.op = OP_ADD;
         default: item_dec.op = OP_SAMPLE;
      endcase
      item_dec.data = req_entry_data;
      item_dec.rnd  = req_random_value;
      item_dec.last = req_batch_last;
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = queue_pop && (fill_ff != 2'd0);

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_dec;
      end
   end

   assign queue_out.valid = (fill_ff != 2'd0);
   assign queue_out.item  = entry_ff[rd_ptr_ff];

endmodule

// File: hdl/rrb_div.sv
// ----------------------------------------------------------------------------
// rrb_div
// Restoring divider, one quotient bit a cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module rrb_div #(
   parameter int VW = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rrb_pkg::RANDOM_WIDTH-1:0] dividend,
   input  logic [VW-1:0]                   divisor,
   output logic                            done,
   output logic [VW-1:0]                   remainder
);
   import rrb_pkg::*;

   localparam int CW = $clog2(RANDOM_WIDTH + 1);

   logic [RANDOM_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VW-1:0]           div_ff, div_in;
   logic [VW-1:0]           rem_ff, rem_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [VW:0]             shifted;
   logic [VW:0]             trial;

   assign shifted = {rem_ff, dvd_ff[RANDOM_WIDTH-1]};
   assign trial   = shifted - {1'b0, div_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(RANDOM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RANDOM_WIDTH-2:0], 1'b0};
         rem_in = (shifted >= {1'b0, div_ff}) ? trial[VW-1:0] : shifted[VW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/rrb_back.sv
// ----------------------------------------------------------------------------
// rrb_back
// Executes queued words: ring store, pointers, sampling and response register.
// ----------------------------------------------------------------------------
module rrb_back #(
   parameter int DEPTH         = 1024,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrb_pkg::rrb_queue_type           queue_in,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rrb_pkg::DATA_WIDTH-1:0]   rsp_read_data,
   output logic [rrb_pkg::FILL_WIDTH-1:0]   rsp_fill_count,
   output logic                             rsp_status,
   output logic                             rsp_last
);
   import rrb_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int PURGE = DEPTH / PURGE_DIVISOR;
   localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);
   localparam logic [AW:0] PURGE_C = (AW + 1)'(PURGE);

   logic [PAYLOAD_WIDTH-1:0] store_mem [DEPTH];

   rrb_state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] idx_in;
   logic          last_ff;
   logic [PAYLOAD_WIDTH-1:0] rd_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic [FILL_WIDTH-1:0] out_fill_ff;
   logic                  out_status_ff;
   logic                  out_last_ff;

   logic free;
   logic is_add;
   logic is_empty;
   logic do_add;
   logic do_empty;
   logic div_start;
   logic load_sample;
   logic div_done;
   logic [AW-1:0] div_rem;

   logic [AW:0]   cnt_inc;
   logic [AW:0]   head_sum;
   logic [AW:0]   idx_sum;
   logic [AW-1:0] new_count;
   logic [31:0]   fill_ext;

   assign free     = !out_valid_ff || rsp_ready;
   assign is_add   = (queue_in.item.op == OP_ADD);
   assign is_empty = (count_ff == '0);

   rrb_div #(
      .VW (AW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (queue_in.item.rnd),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_in.valid && !is_add && !is_empty) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      do_add      = 1'b0;
      do_empty    = 1'b0;
      div_start   = 1'b0;
      load_sample = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_in.valid) begin
               if (is_add) begin
                  do_add = free;
               end else if (is_empty) begin
                  do_empty = free;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_RESP: begin
            load_sample = free;
         end
         default: begin
         end
      endcase
   end

   assign queue_pop = do_add || do_empty || div_start;

   // add: advance tail, bump count, purge oldest fifth on saturation
   assign cnt_inc  = {1'b0, count_ff} + (AW + 1)'(1);
   assign head_sum = {1'b0, head_ff} + PURGE_C;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      new_count = cnt_inc[AW-1:0];
      if (cnt_inc >= DEPTH_C) begin
         new_count = AW'(cnt_inc - PURGE_C);
         head_in   = (head_sum >= DEPTH_C) ? AW'(head_sum - DEPTH_C) : head_sum[AW-1:0];
      end
      tail_in  = ({1'b0, tail_ff} == DEPTH_C - (AW + 1)'(1)) ? '0 : tail_ff + AW'(1);
      count_in = new_count;
      if (!do_add) begin
         head_in  = head_ff;
         tail_in  = tail_ff;
         count_in = count_ff;
      end
   end

   assign idx_sum = {1'b0, div_rem} + {1'b0, head_ff};
   assign idx_in  = (idx_sum >= DEPTH_C) ? AW'(idx_sum - DEPTH_C) : idx_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         store_mem[tail_ff] <= queue_in.item.data[PAYLOAD_WIDTH-1:0];
      end
      if (state_ff == ST_READ) begin
         rd_ff <= store_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         last_ff <= queue_in.item.last;
      end
      if (div_done) begin
         idx_ff <= idx_in;
      end
   end

   assign out_valid_in = (do_add || do_empty || load_sample) ? 1'b1 :
                         (rsp_ready ? 1'b0 : out_valid_ff);

   assign fill_ext = (do_add) ? 32'(new_count) : 32'(count_ff);

   always_ff @(posedge clock) begin
      if (do_add || do_empty) begin
         out_data_ff   <= '0;
         out_fill_ff   <= fill_ext[FILL_WIDTH-1:0];
         out_status_ff <= do_empty;
         out_last_ff   <= queue_in.item.last;
      end else if (load_sample) begin
         out_data_ff   <= DATA_WIDTH'(rd_ff);
         out_fill_ff   <= fill_ext[FILL_WIDTH-1:0];
         out_status_ff <= 1'b0;
         out_last_ff   <= last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = out_data_ff;
   assign rsp_fill_count = out_fill_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_last       = out_last_ff;

endmodule

// File: hdl/replay_ring_buffer_with_purge.sv
// ----------------------------------------------------------------------------
// replay_ring_buffer_with_purge
// Replay ring of DEPTH payload words with purge of the oldest fifth when full.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per item. req_kind 0 stores req_entry_data at the
//   tail; req_kind 1 samples the entry (random_value mod fill) past the head.
//   rsp_ channel: exactly one word per request, in order, carrying the
//   sampled data (zero for adds and empty samples), the fill count after
//   the item, an empty-sample status flag and a copy of req_batch_last.
//   A two-word queue decouples the request decoder from the executor.
//   An add or empty sample passes the executor at one word per cycle
//   while the response register is free. A non-empty sample holds the
//   executor through a start, the 31 steps of the restoring divider
//   that reduces the random value by the fill count, then index, store
//   read and response.
//   Reset clears pointers and fill count; stored words are undefined until
//   written and are never read before. If the receiver stalls, the response
//   register holds and the executor waits; requests still fill the queue.
// ----------------------------------------------------------------------------
module replay_ring_buffer_with_purge #(
   parameter int DEPTH         = 1024,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [rrb_pkg::DATA_WIDTH-1:0]       req_entry_data,
   input  logic [rrb_pkg::RANDOM_WIDTH-1:0]     req_random_value,
   input  logic                                 req_batch_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rrb_pkg::DATA_WIDTH-1:0]       rsp_read_data,
   output logic [rrb_pkg::FILL_WIDTH-1:0]       rsp_fill_count,
   output logic                                 rsp_status,
   output logic                                 rsp_last
);
   import rrb_pkg::*;

   rrb_queue_type queue;
   logic          queue_pop;

   rrb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_entry_data   (req_entry_data),
      .req_random_value (req_random_value),
      .req_batch_last   (req_batch_last),
      .queue_out        (queue),
      .queue_pop        (queue_pop)
   );

   rrb_back #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_in       (queue),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_count (rsp_fill_count),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// File: verif/tb_replay_ring_buffer_with_purge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_replay_ring_buffer_with_purge
// Self-checking bench for the replay ring: adds, samples and purge on fill.
// A local copy of the ring, its head, tail and fill follows every accepted
// request word and queues the response word it must produce. Responses are
// checked in order, field by field. Directed words cover empty samples,
// extreme payloads and random values. Random mixes run under sender and
// receiver idling. A long fill crosses the saturation purge. Two
// pressure runs follow: a long receiver hold-off that backs up the request
// side, and a sender pause until all responses are in.
// ----------------------------------------------------------------------------
module tb_replay_ring_buffer_with_purge;
   import rrb_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int PURGE_LEN  = RING_DEPTH / PURGE_DIVISOR;

   typedef struct {
      logic [DATA_WIDTH-1:0] data;
      logic [FILL_WIDTH-1:0] fill;
      logic                  status;
      logic                  last;
   } ring_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = 1'b0;
   logic [DATA_WIDTH-1:0]   req_entry_data = '0;
   logic [RANDOM_WIDTH-1:0] req_random_value = '0;
   logic                    req_batch_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DATA_WIDTH-1:0]   rsp_read_data;
   logic [FILL_WIDTH-1:0]   rsp_fill_count;
   logic                    rsp_status;
   logic                    rsp_last;

   // local copy of the ring
   logic [DATA_WIDTH-1:0] ring_copy [0:RING_DEPTH-1];
   int unsigned           head_idx = 0;
   int unsigned           tail_idx = 0;
   int unsigned           held = 0;
   int unsigned           purge_total = 0;

   ring_word_type awaited_words [$];
   int            fail_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_request = 0;
   int            hold_left = 0;

   replay_ring_buffer_with_purge uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_entry_data   (req_entry_data),
      .req_random_value (req_random_value),
      .req_batch_last   (req_batch_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic predict_ring_word(input rrb_op_type op, input logic [DATA_WIDTH-1:0] data,
                                    input logic [RANDOM_WIDTH-1:0] rnd, input logic last);
      ring_word_type w;
      int unsigned   pick;
      w.data   = '0;
      w.status = 1'b0;
      w.last   = last;
      if (op == OP_ADD) begin
         ring_copy[RING_AW'(tail_idx)] = data;
         tail_idx = (tail_idx + 1) % RING_DEPTH;
         held++;
         if (held >= RING_DEPTH) begin
            held -= PURGE_LEN;
            head_idx = (head_idx + PURGE_LEN) % RING_DEPTH;
            purge_total++;
         end
      end else if (held == 0) begin
         w.status = 1'b1;
      end else begin
         pick   = ((rnd % held) + head_idx) % RING_DEPTH;
         w.data = ring_copy[RING_AW'(pick)];
      end
      w.fill = FILL_WIDTH'(held);
      awaited_words = {awaited_words, w};
   endtask

   // called at a rising edge; leaves valid high after acceptance
   task automatic send_word(input rrb_op_type op, input logic [DATA_WIDTH-1:0] data,
                            input logic [RANDOM_WIDTH-1:0] rnd, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= op;
      req_entry_data   <= data;
      req_random_value <= rnd;
      req_batch_last   <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_ring_word(op, data, rnd, last);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [DATA_WIDTH-1:0] rand_data();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [RANDOM_WIDTH-1:0] rand_pick();
      return RANDOM_WIDTH'($urandom);
   endfunction

   task automatic send_random_mix(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 65)
            send_word(OP_ADD, rand_data(), rand_pick(), $urandom_range(3) == 0);
         else
            send_word(OP_SAMPLE, rand_data(), rand_pick(), $urandom_range(3) == 0);
      end
   endtask

   task automatic test_empty_and_extremes();
      send_word(OP_SAMPLE, '1, '1, 1'b1);
      send_word(OP_SAMPLE, '0, '0, 1'b0);
      send_word(OP_ADD, '0, '0, 1'b0);
      send_word(OP_SAMPLE, '1, '1, 1'b1);
      send_word(OP_ADD, '1, '1, 1'b1);
      send_word(OP_ADD, 64'h8000_0000_0000_0000, '0, 1'b0);
      send_word(OP_ADD, 64'h5555_5555_5555_5555, 31'h2AAA_AAAA, 1'b0);
      send_word(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 31'h5555_5555, 1'b1);
      send_word(OP_ADD, 64'h0000_0000_0000_0001, '0, 1'b0);
      send_word(OP_SAMPLE, '0, '0, 1'b0);
      send_word(OP_SAMPLE, '0, '1, 1'b1);
      send_word(OP_SAMPLE, '1, 31'd4, 1'b0);
      send_word(OP_SAMPLE, '0, 31'd5, 1'b0);
      send_word(OP_SAMPLE, '0, 31'h4000_0000, 1'b1);
      send_word(OP_SAMPLE, '0, 31'h2AAA_AAAA, 1'b0);
      send_word(OP_SAMPLE, '0, 31'h5555_5555, 1'b1);
   endtask

   // fill through the purge, with a sample now and then
   task automatic test_saturation_purge();
      int unsigned start;
      int          n;
      start = purge_total;
      n = 0;
      while (purge_total < start + 1) begin
         send_word(OP_ADD, rand_data(), rand_pick(), $urandom_range(3) == 0);
         n++;
         if (n % 64 == 0)
            send_word(OP_SAMPLE, rand_data(), rand_pick(), 1'b1);
      end
      send_word(OP_SAMPLE, '0, '0, 1'b0);
      send_word(OP_SAMPLE, '0, '1, 1'b1);
      send_word(OP_SAMPLE, '0, 31'(held - 1), 1'b0);
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      send_random_mix(24);
      wait_drain();
      for (int i = 0; i < 6; i++)
         send_word(OP_SAMPLE, rand_data(), rand_pick(), i == 5);
      wait_drain();
      send_random_mix(10);
   endtask

   always @(posedge clock) begin
      ring_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: response word with nothing awaited", $time);
            fail_count++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_read_data !== want.data) begin
               $display("%0t: read_data exp %h got %h", $time, want.data, rsp_read_data);
               fail_count++;
            end
            if (rsp_fill_count !== want.fill) begin
               $display("%0t: fill_count exp %0d got %0d", $time, want.fill, rsp_fill_count);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status exp %b got %b", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last exp %b got %b", $time, want.last, rsp_last);
               fail_count++;
            end
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      recv_idle_pct = 81;
      test_empty_and_extremes();
      send_random_mix(30);
      test_saturation_purge();

      send_idle_pct = 81;
      recv_idle_pct = 7;
      send_random_mix(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      send_random_mix(40);

      wait_drain();
      repeat (64) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
hdl/rrb_pkg.sv
hdl/rrb_front.sv
hdl/rrb_div.sv
hdl/rrb_back.sv
hdl/replay_ring_buffer_with_purge.sv
verif/tb_replay_ring_buffer_with_purge.sv
